### sv/abp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_pkg
// Shared types, constants and helper functions of the autofire button pulser.
// ----------------------------------------------------------------------------
package abp_pkg;

  localparam int TimeW   = 32;
  localparam int CfgW    = 16;
  localparam int WinW    = 17;
  localparam int LfsrW   = 16;
  localparam int CfgIdxW = 3;

  localparam logic [LfsrW-1:0] LfsrTaps = 16'hB400;
  localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;
  localparam logic [7:0]       JitterSpan = 8'd19;
  localparam logic [12:0]      JitterRecip = 13'd27;

  typedef enum logic [CfgIdxW-1:0] {
    RegFirstDelay   = 3'd0,
    RegRelease      = 3'd1,
    RegPress        = 3'd2,
    RegUsePrimary   = 3'd3,
    RegUseSecondary = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StDelay  = 3'b010,
    StRepeat = 3'b100
  } st_e;

  typedef struct packed {
    logic [CfgW-1:0] first_delay_ms;
    logic [CfgW-1:0] release_ms;
    logic [CfgW-1:0] press_ms;
    logic            use_primary;
    logic            use_secondary;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             primary_pushed;
    logic             secondary_pushed;
    logic             paused;
  } smp_t;

  typedef struct packed {
    logic active;
    logic force_release;
  } res_t;

  function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] x);
    logic [LfsrW-1:0] s;
    s = x >> 1;
    if (x[0]) begin
      s = s ^ LfsrTaps;
    end
    return s;
  endfunction

  // Residue mod 19: fold by 256 == 9 (mod 19), then reciprocal estimate.
  function automatic logic [4:0] mod19(input logic [LfsrW-1:0] x);
    logic [11:0] a;
    logic [8:0]  b;
    logic [8:0]  c;
    logic [7:0]  d;
    logic [12:0] m;
    logic [3:0]  q;
    logic [7:0]  r;
    a = {1'b0, x[15:8], 3'b000} + 12'(x[15:8]) + 12'(x[7:0]);
    b = 9'({a[11:8], 3'b000}) + 9'(a[11:8]) + 9'(a[7:0]);
    c = 9'({b[8], 3'b000}) + 9'(b[8]) + 9'(b[7:0]);
    d = 8'(9'({c[8], 3'b000}) + 9'(c[8]) + 9'(c[7:0]));
    m = 13'(d) * JitterRecip;
    q = m[12:9];
    r = d - 8'(8'(q) * JitterSpan);
    return r[4:0];
  endfunction

endpackage

### sv/abp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_sample_if / abp_result_if
// Valid/ready channels carrying button samples in and autofire results out.
// ----------------------------------------------------------------------------
interface abp_sample_if;
  logic                      valid;
  logic                      ready;
  logic [abp_pkg::TimeW-1:0] now_ms;
  logic                      primary_pushed;
  logic                      secondary_pushed;
  logic                      paused;

  modport source (output valid, output now_ms, output primary_pushed,
                  output secondary_pushed, output paused, input ready);
  modport sink   (input valid, input now_ms, input primary_pushed,
                  input secondary_pushed, input paused, output ready);
endinterface

interface abp_result_if;
  logic valid;
  logic ready;
  logic active;
  logic force_release;

  modport source (output valid, output active, output force_release, input ready);
  modport sink   (input valid, input active, input force_release, output ready);
endinterface

### sv/autofire_button_pulser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autofire_button_pulser_unit
// Turbo autofire: pulses a forced release of the target button while the
// configured button combination is held.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the result side accepts, and returns
// one result word per sample through the input register, then the result
// register. The rate of one word per cycle is set by the hold/repeat state
// update, applied once per accepted sample, so that each sample sees the
// state left by the one before it. Configuration registers hold their reset
// values right after reset; no clearing pass is needed.
module autofire_button_pulser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [abp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [abp_pkg::CfgW-1:0]    cfg_wdata_i,
  abp_sample_if.sink                  sample_i,
  abp_result_if.source                result_o
);
  import abp_pkg::*;

  cfg_t cfg;
  smp_t smp_q;
  res_t res;
  res_t res_q;
  logic in_vld_q;
  logic out_vld_q;
  logic adv;

  abp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  abp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .smp_i  (smp_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv            = in_vld_q && (!out_vld_q || result_o.ready);
  assign sample_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        in_vld_q <= sample_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      smp_q.now_ms           <= sample_i.now_ms;
      smp_q.primary_pushed   <= sample_i.primary_pushed;
      smp_q.secondary_pushed <= sample_i.secondary_pushed;
      smp_q.paused           <= sample_i.paused;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.active        = res_q.active;
  assign result_o.force_release = res_q.force_release;

  a_force_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!res_q.force_release || res_q.active))
    else $error("force_release without active");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q) else $error("advanced word missing from result stage");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(smp_q))
    else $error("pending input word dropped");

  a_paused_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && smp_q.paused |=> !res_q.active)
    else $error("paused sample reported active");

endmodule

### sv/abp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module abp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [abp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [abp_pkg::CfgW-1:0]        cfg_wdata_i,
  output abp_pkg::cfg_t                   cfg_o
);
  import abp_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegFirstDelay:   cfg_d.first_delay_ms = cfg_wdata_i;
        RegRelease:      cfg_d.release_ms     = cfg_wdata_i;
        RegPress:        cfg_d.press_ms       = cfg_wdata_i;
        RegUsePrimary:   cfg_d.use_primary    = cfg_wdata_i[0];
        RegUseSecondary: cfg_d.use_secondary  = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_delay_ms <= '0;
      cfg_q.release_ms     <= '0;
      cfg_q.press_ms       <= '0;
      cfg_q.use_primary    <= 1'b1;
      cfg_q.use_secondary  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/abp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_engine
// Hold/delay/repeat state, window timing and LFSR jitter for one sample.
// ----------------------------------------------------------------------------
module abp_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  abp_pkg::smp_t smp_i,
  input  abp_pkg::cfg_t cfg_i,
  output abp_pkg::res_t res_o
);
  import abp_pkg::*;

  st_e              st_q, st_d;
  logic [TimeW-1:0] phase_q, phase_d;
  logic [WinW-1:0]  rel_q, rel_d;
  logic [WinW-1:0]  prs_q, prs_d;
  logic [LfsrW-1:0] lfsr_q, lfsr_d;

  logic [TimeW-1:0] elapsed;
  logic [WinW:0]    cycle_end;
  logic             combo;
  logic [LfsrW-1:0] lfsr1, lfsr2, lfsr_new;
  logic [4:0]       jit_rel, jit_prs;
  logic [WinW-1:0]  win_rel, win_prs;
  logic             rel_odd, prs_odd;

  assign rel_odd   = cfg_i.release_ms[0];
  assign prs_odd   = cfg_i.press_ms[0];
  assign lfsr1     = lfsr_step(lfsr_q);
  assign lfsr2     = lfsr_step(lfsr1);
  assign jit_rel   = mod19(lfsr1);
  assign jit_prs   = mod19(rel_odd ? lfsr2 : lfsr1);
  assign win_rel   = WinW'(cfg_i.release_ms) + (rel_odd ? WinW'(jit_rel) : '0);
  assign win_prs   = WinW'(cfg_i.press_ms) + (prs_odd ? WinW'(jit_prs) : '0);
  assign lfsr_new  = (rel_odd && prs_odd) ? lfsr2 :
                     (rel_odd || prs_odd) ? lfsr1 : lfsr_q;

  assign elapsed   = smp_i.now_ms - phase_q;
  assign cycle_end = (WinW + 1)'(rel_q) + (WinW + 1)'(prs_q);

  assign combo = (cfg_i.use_primary && cfg_i.use_secondary &&
                  smp_i.primary_pushed && smp_i.secondary_pushed) ||
                 (!cfg_i.use_primary && smp_i.secondary_pushed) ||
                 (!cfg_i.use_secondary && smp_i.primary_pushed);

  always_comb begin
    st_d    = st_q;
    phase_d = phase_q;
    rel_d   = rel_q;
    prs_d   = prs_q;
    lfsr_d  = lfsr_q;
    res_o   = '0;
    if (!smp_i.paused && combo) begin
      res_o.active = 1'b1;
      unique case (st_q)
        StIdle: begin
          st_d    = StDelay;
          phase_d = smp_i.now_ms;
        end
        StDelay: begin
          if (elapsed > TimeW'(cfg_i.first_delay_ms)) begin
            st_d    = StRepeat;
            phase_d = smp_i.now_ms;
            rel_d   = win_rel;
            prs_d   = win_prs;
            lfsr_d  = lfsr_new;
          end
        end
        StRepeat: begin
          if (elapsed <= TimeW'(rel_q)) begin
            res_o.force_release = 1'b1;
          end else if (elapsed > TimeW'(cycle_end)) begin
            phase_d = smp_i.now_ms;
            rel_d   = win_rel;
            prs_d   = win_prs;
            lfsr_d  = lfsr_new;
          end
        end
        default: st_d = StIdle;
      endcase
    end else if (!smp_i.paused) begin
      st_d = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      phase_q <= '0;
      rel_q   <= '0;
      prs_q   <= '0;
      lfsr_q  <= LfsrSeed;
    end else if (en_i) begin
      st_q    <= st_d;
      phase_q <= phase_d;
      rel_q   <= rel_d;
      prs_q   <= prs_d;
      lfsr_q  <= lfsr_d;
    end
  end

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("jitter LFSR reached the all-zero lock state");

  a_idle_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StRepeat |-> !res_o.force_release)
    else $error("release forced outside repeat phase");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && smp_i.paused |=> $stable(st_q) && $stable(phase_q) && $stable(lfsr_q))
    else $error("state changed on a paused sample");

endmodule
